// File: rtl/letterbox_display_rect_macros.svh
// Assertion macros for the letterbox fit block.
`ifndef LETTERBOX_DISPLAY_RECT_MACROS_SVH
`define LETTERBOX_DISPLAY_RECT_MACROS_SVH
`ifndef ASSERT_OFF
`define LDR_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define LDR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define LDR_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define LDR_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

// File: rtl/ldr_pkg.sv
// Types and constants for the letterbox fit pipeline.
package ldr_pkg;
    localparam int QBITS   = 14;
    localparam int RBITS   = 43;
    localparam int DBITS   = 29;
    localparam int DSTEPS  = 7;
    localparam int NST     = 2 + DSTEPS;

    typedef struct packed {
        logic [12:0]      left;
        logic [12:0]      top;
        logic [12:0]      sw;
        logic [12:0]      sh;
        logic [DBITS-1:0] num;
        logic [DBITS-1:0] den;
        logic [RBITS-1:0] rem_a;
        logic [RBITS-1:0] rem_b;
        logic [QBITS-1:0] q_a;
        logic [QBITS-1:0] q_b;
        logic             ovf_a;
        logic             ovf_b;
    } t_stage;

    typedef struct packed {
        logic [12:0] left;
        logic [12:0] top;
        logic [12:0] sw;
        logic [12:0] sh;
        logic [12:0] w;
        logic [12:0] h;
    } t_rnd;
endpackage

// File: rtl/letterbox_display_rect.sv
// Letterbox fit: pipelined aspect-preserving fit and centring of a picture.
// One item per cycle while the output is not stalled, through two multiply stages, seven stages of
// two restoring-division bits each (both quotients in parallel), a rounding
// stage and an offset stage that is also the output register. The whole
// pipeline halts while a result waits at the output.
`include "letterbox_display_rect_macros.svh"
module letterbox_display_rect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [12:0] i_screen_left,
    input  logic [12:0] i_screen_top,
    input  logic [12:0] i_screen_width,
    input  logic [12:0] i_screen_height,
    input  logic [12:0] i_picture_width,
    input  logic [12:0] i_picture_height,
    input  logic [15:0] i_sar_num,
    input  logic [15:0] i_sar_den,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [13:0] o_rect_x,
    output logic [13:0] o_rect_y,
    output logic [12:0] o_rect_width,
    output logic [12:0] o_rect_height
);
    localparam int NST = ldr_pkg::NST;

    logic                 en;
    logic [NST+1:0]       r_v;
    ldr_pkg::t_stage      r_st [NST];
    ldr_pkg::t_stage      n_st [NST];
    ldr_pkg::t_rnd        r_rnd;
    ldr_pkg::t_rnd        n_rnd;
    logic [13:0]          r_x, r_y;
    logic [12:0]          r_w, r_h;

    assign en         = !r_v[NST+1] || i_out_ready;
    assign o_in_ready = en;

    always_comb begin
        logic [15:0] sn, sd;
        logic [12:0] ph;
        ldr_pkg::t_stage t;
        logic [42:0] pa, pb;
        sn = i_sar_num;
        sd = i_sar_den;
        if (sn == 16'd0 || sd == 16'd0) begin
            sn = 16'd1;
            sd = 16'd1;
        end
        ph = (i_picture_height == 13'd0) ? 13'd1 : i_picture_height;
        t       = '0;
        t.left  = i_screen_left;
        t.top   = i_screen_top;
        t.sw    = i_screen_width;
        t.sh    = i_screen_height;
        t.num   = 29'(sn) * 29'(i_picture_width);
        t.den   = 29'(sd) * 29'(ph);
        n_st[0] = t;

        t     = r_st[0];
        pa    = 43'(t.sh) * 43'(t.num);
        pb    = 43'(t.sw) * 43'(t.den);
        t.rem_a = pa;
        t.rem_b = pb;
        t.q_a   = '0;
        t.q_b   = '0;
        t.ovf_a = pa >= {t.den, 14'd0};
        t.ovf_b = pb >= {t.num, 14'd0};
        n_st[1] = t;

        for (int j = 0; j < ldr_pkg::DSTEPS; j++) begin
            t = r_st[j+1];
            for (int b = 0; b < 2; b++) begin
                if (t.rem_a >= (43'(t.den) << (13 - 2*j - b))) begin
                    t.rem_a = t.rem_a - (43'(t.den) << (13 - 2*j - b));
                    t.q_a   = t.q_a | (14'd1 << (13 - 2*j - b));
                end
                if (t.rem_b >= (43'(t.num) << (13 - 2*j - b))) begin
                    t.rem_b = t.rem_b - (43'(t.num) << (13 - 2*j - b));
                    t.q_b   = t.q_b | (14'd1 << (13 - 2*j - b));
                end
            end
            n_st[j+2] = t;
        end
    end

    always_comb begin
        ldr_pkg::t_stage s;
        logic [43:0] ha, hb;
        logic        up_a, up_b, big;
        logic [14:0] wa, wb;
        s    = r_st[NST-1];
        ha   = {s.rem_a, 1'b0};
        hb   = {s.rem_b, 1'b0};
        up_a = (ha > 44'(s.den)) || (ha == 44'(s.den) && s.q_a[0]);
        up_b = (hb > 44'(s.num)) || (hb == 44'(s.num) && s.q_b[0]);
        wa   = (15'(s.q_a) + 15'(up_a)) & ~15'd1;
        wb   = (15'(s.q_b) + 15'(up_b)) & ~15'd1;
        big  = s.ovf_a || (wa > 15'(s.sw));
        n_rnd.left = s.left;
        n_rnd.top  = s.top;
        n_rnd.sw   = s.sw;
        n_rnd.sh   = s.sh;
        if (big) begin
            n_rnd.w = s.sw;
            if (s.num == '0) begin
                n_rnd.h = 13'd0;
            end else if (s.ovf_b || wb > 15'(s.sh)) begin
                n_rnd.h = s.sh;
            end else begin
                n_rnd.h = wb[12:0];
            end
        end else begin
            n_rnd.w = wa[12:0];
            n_rnd.h = s.sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NST; k++) begin
                r_st[k] <= n_st[k];
            end
            r_rnd <= n_rnd;
            r_x   <= 14'(r_rnd.left) + 14'((r_rnd.sw - r_rnd.w) >> 1);
            r_y   <= 14'(r_rnd.top) + 14'((r_rnd.sh - r_rnd.h) >> 1);
            r_w   <= (r_rnd.w == 13'd0) ? 13'd1 : r_rnd.w;
            r_h   <= (r_rnd.h == 13'd0) ? 13'd1 : r_rnd.h;
        end
    end

    assign o_out_valid   = r_v[NST+1];
    assign o_rect_x      = r_x;
    assign o_rect_y      = r_y;
    assign o_rect_width  = r_w;
    assign o_rect_height = r_h;

    `LDR_ASSERT_IMPL(a_size_nonzero, i_clk, i_rst_n, o_out_valid,
        o_rect_width != 13'd0 && o_rect_height != 13'd0)
    `LDR_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, !o_in_ready,
        o_out_valid && !i_out_ready)
    `LDR_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid)
endmodule
